>>> hw/rtl/interval_range_map_core_defines.svh
// assertion macros for the interval range map core
// users must have clk and rst_n in scope
`ifndef INTERVAL_RANGE_MAP_CORE_DEFINES_SVH
`define INTERVAL_RANGE_MAP_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define IRM_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define IRM_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/irm_pkg.sv
// shared types and constants for the interval range map core
// no dependencies
package irm_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 8;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

    localparam logic ACT_ASSIGN = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                         action;
        logic signed [KEY_BITS-1:0]   range_start;
        logic signed [KEY_BITS-1:0]   range_stop;
        logic        [VALUE_BITS-1:0] fill_value;
        logic signed [KEY_BITS-1:0]   query_key;
    } req_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] read_value;
        logic [1:0]            status;
    } rsp_t;

    typedef struct packed {
        logic signed [KEY_BITS-1:0] key;
        logic [VALUE_BITS-1:0]      value;
    } entry_t;

endpackage

>>> hw/rtl/irm_ram.sv
// breakpoint memory bank: one write port, one registered read port
// depends on irm_pkg
module irm_ram (
    input  logic                           clk,
    input  logic                           we,
    input  logic [irm_pkg::IDX_BITS-1:0]   waddr,
    input  irm_pkg::entry_t                wdata,
    input  logic [irm_pkg::IDX_BITS-1:0]   raddr,
    output irm_pkg::entry_t                rdata
);

    irm_pkg::entry_t mem [irm_pkg::TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/interval_range_map_core.sv
// top level of the interval range map core: sequencer over two table banks
// depends on irm_pkg, irm_ram and interval_range_map_core_defines.svh
//
// usage
//   request channel req_valid/req_stall/req_data carries assign or lookup
//   requests; response channel rsp_valid/rsp_stall/rsp_data returns one
//   result per request, in order. default_value is written with cfg_we and
//   cfg_wdata; the user must do so while the block is idle (not enforced).
// sequencing
//   one request at a time. the sequencer walks the stored breakpoints through
//   a single read port, reading then evaluating each entry, with one compare
//   pair shared by every step. a lookup stops at the first key past the
//   query; an assign scans all stored entries and pushes its two ends.
//   an empty interval skips the scan. an assign writes the new table into
//   the spare bank and swaps banks, unless the table would overflow.
// reset
//   the table is empty and the default value is zero; no clearing pass.
// stall
//   a finished result sits in the response register; the next request is
//   taken meanwhile, and its own result waits until that register is free.
`include "interval_range_map_core_defines.svh"

module interval_range_map_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  irm_pkg::req_t                   req_data,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output irm_pkg::rsp_t                   rsp_data,
    input  logic                            cfg_we,
    input  logic [irm_pkg::VALUE_BITS-1:0]  cfg_wdata
);

    typedef enum logic [2:0] {S_IDLE, S_RD, S_EV, S_PB, S_PE, S_DONE} state_t;

    localparam logic [irm_pkg::CNT_BITS-1:0] DEPTH_C =
        irm_pkg::CNT_BITS'(irm_pkg::TABLE_DEPTH);

    state_t state_reg, state_next;
    logic   sel_reg, sel_next;
    logic   act_reg, act_next;
    logic   bdone_reg, bdone_next, edone_reg, edone_next, ovf_reg, ovf_next;
    logic [irm_pkg::CNT_BITS-1:0]   cnt_reg, cnt_next, i_reg, i_next, n_reg, n_next;
    logic signed [irm_pkg::KEY_BITS-1:0] b_reg, b_next, e_reg, e_next;
    logic [irm_pkg::VALUE_BITS-1:0] fill_reg, fill_next, acc_reg, acc_next;
    logic [irm_pkg::VALUE_BITS-1:0] prev_reg, prev_next, dflt_reg, dflt_next;
    logic [1:0]                     stat_reg, stat_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    irm_pkg::rsp_t                  rsp_reg, rsp_next;

    logic            push;
    irm_pkg::entry_t push_e;
    logic            wr_en;
    irm_pkg::entry_t rd0, rd1, rd;
    logic            ge_b, le_e;

    irm_ram u_bank0 (
        .clk   (clk),
        .we    (wr_en && sel_reg),
        .waddr (n_reg[irm_pkg::IDX_BITS-1:0]),
        .wdata (push_e),
        .raddr (i_reg[irm_pkg::IDX_BITS-1:0]),
        .rdata (rd0)
    );

    irm_ram u_bank1 (
        .clk   (clk),
        .we    (wr_en && !sel_reg),
        .waddr (n_reg[irm_pkg::IDX_BITS-1:0]),
        .wdata (push_e),
        .raddr (i_reg[irm_pkg::IDX_BITS-1:0]),
        .rdata (rd1)
    );

    assign rd   = sel_reg ? rd1 : rd0;
    assign ge_b = rd.key >= b_reg;
    assign le_e = rd.key <= e_reg;

    // a push that repeats the value in force is dropped
    assign wr_en = push && (push_e.value != prev_reg) && (n_reg < DEPTH_C);

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        act_next       = act_reg;
        bdone_next     = bdone_reg;
        edone_next     = edone_reg;
        ovf_next       = ovf_reg;
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        n_next         = n_reg;
        b_next         = b_reg;
        e_next         = e_reg;
        fill_next      = fill_reg;
        acc_next       = acc_reg;
        prev_next      = prev_reg;
        dflt_next      = cfg_we ? cfg_wdata : dflt_reg;
        stat_next      = stat_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        push           = 1'b0;
        push_e         = rd;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    act_next   = req_data.action;
                    b_next     = req_data.range_start;
                    e_next     = (req_data.action == irm_pkg::ACT_LOOKUP) ?
                                 req_data.query_key : req_data.range_stop;
                    fill_next  = req_data.fill_value;
                    acc_next   = dflt_reg;
                    prev_next  = dflt_reg;
                    i_next     = '0;
                    n_next     = '0;
                    bdone_next = 1'b0;
                    edone_next = 1'b0;
                    ovf_next   = 1'b0;
                    stat_next  = irm_pkg::ST_DONE;
                    if (req_data.action == irm_pkg::ACT_ASSIGN &&
                        !(req_data.range_start < req_data.range_stop))
                    begin
                        stat_next  = irm_pkg::ST_EMPTY;
                        acc_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_EV;
            end
            S_EV:
            begin
                if (act_reg == irm_pkg::ACT_LOOKUP)
                begin
                    if (i_reg == cnt_reg || !le_e)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        acc_next   = rd.value;
                        i_next     = i_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
                else if (i_reg == cnt_reg)
                begin
                    if (!bdone_reg)
                    begin
                        state_next = S_PB;
                    end
                    else if (!edone_reg)
                    begin
                        state_next = S_PE;
                    end
                    else
                    begin
                        if (ovf_reg)
                        begin
                            stat_next = irm_pkg::ST_FULL;
                        end
                        else
                        begin
                            sel_next = !sel_reg;
                            cnt_next = n_reg;
                        end
                        i_next     = '0;
                        acc_next   = '0;
                        state_next = S_DONE;
                    end
                end
                else if (ge_b && !bdone_reg)
                begin
                    state_next = S_PB;
                end
                else if (!le_e && !edone_reg)
                begin
                    state_next = S_PE;
                end
                else
                begin
                    // entries inside [b, e] are dropped
                    push = !ge_b || !le_e;
                    if (le_e)
                    begin
                        acc_next = rd.value;
                    end
                    i_next     = i_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_PB:
            begin
                push         = 1'b1;
                push_e.key   = b_reg;
                push_e.value = fill_reg;
                bdone_next   = 1'b1;
                state_next   = S_EV;
            end
            S_PE:
            begin
                push         = 1'b1;
                push_e.key   = e_reg;
                push_e.value = acc_reg;
                edone_next   = 1'b1;
                state_next   = S_EV;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.read_value = acc_reg;
                    rsp_next.status     = stat_reg;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (push && (push_e.value != prev_reg))
        begin
            prev_next = push_e.value;
            if (n_reg < DEPTH_C)
            begin
                n_next = n_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= 1'b0;
            cnt_reg       <= '0;
            dflt_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            act_reg       <= irm_pkg::ACT_ASSIGN;
            bdone_reg     <= 1'b0;
            edone_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            n_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            cnt_reg       <= cnt_next;
            dflt_reg      <= dflt_next;
            rsp_valid_reg <= rsp_valid_next;
            act_reg       <= act_next;
            bdone_reg     <= bdone_next;
            edone_reg     <= edone_next;
            ovf_reg       <= ovf_next;
            i_reg         <= i_next;
            n_reg         <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg    <= b_next;
        e_reg    <= e_next;
        fill_reg <= fill_next;
        acc_reg  <= acc_next;
        prev_reg <= prev_next;
        stat_reg <= stat_next;
        rsp_reg  <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    `IRM_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= DEPTH_C, "entry count past table depth")
    `IRM_ASSERT_ALWAYS(a_scan_bound, i_reg <= cnt_reg, "scan index past entry count")
    `IRM_ASSERT_IMPLY(a_wr_room, wr_en, n_reg < DEPTH_C && act_reg == irm_pkg::ACT_ASSIGN, "no room")
    `IRM_ASSERT_IMPLY(a_ovf_keep, state_reg == S_EV && ovf_reg, sel_next == sel_reg, "bank swap")

endmodule

>>> dv/interval_range_map_core_tb.sv
// self-checking testbench for interval_range_map_core: assigns and lookups
// checked against a behavioral breakpoint table; depends on irm_pkg
`timescale 1ns / 100ps

module interval_range_map_core_tb;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    irm_pkg::req_t req_data = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    irm_pkg::rsp_t rsp_data;
    logic cfg_we = 1'b0;
    logic [irm_pkg::VALUE_BITS-1:0] cfg_wdata = '0;

    interval_range_map_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // shadow of the breakpoint table
    logic signed [irm_pkg::KEY_BITS-1:0] map_keys[$];
    logic [irm_pkg::VALUE_BITS-1:0]      map_vals[$];
    logic [irm_pkg::VALUE_BITS-1:0]      map_default = '0;

    irm_pkg::req_t pending_reqs[$];
    irm_pkg::rsp_t expected_rsps[$];
    int   error_count = 0;
    int   gap_left = 0;
    int   stall_left = 0;

    function automatic logic [irm_pkg::VALUE_BITS-1:0] value_at(
        logic signed [irm_pkg::KEY_BITS-1:0] k);
        logic [irm_pkg::VALUE_BITS-1:0] v;
        v = map_default;
        foreach (map_keys[i])
        begin
            if (map_keys[i] > k)
                break;
            v = map_vals[i];
        end
        return v;
    endfunction

    function automatic irm_pkg::rsp_t apply_request(irm_pkg::req_t r);
        irm_pkg::rsp_t o;
        logic signed [irm_pkg::KEY_BITS-1:0] nk[$];
        logic [irm_pkg::VALUE_BITS-1:0] nv[$];
        logic signed [irm_pkg::KEY_BITS-1:0] ck[$];
        logic [irm_pkg::VALUE_BITS-1:0] cv[$];
        logic [irm_pkg::VALUE_BITS-1:0] end_val;
        logic [irm_pkg::VALUE_BITS-1:0] prev;
        o = '0;
        if (r.action == irm_pkg::ACT_LOOKUP)
        begin
            o.read_value = value_at(r.query_key);
            return o;
        end
        if (r.range_start >= r.range_stop)
        begin
            o.status = irm_pkg::ST_EMPTY;
            return o;
        end
        end_val = value_at(r.range_stop);
        foreach (map_keys[i])
            if (map_keys[i] < r.range_start)
            begin
                ck.push_back(map_keys[i]);
                cv.push_back(map_vals[i]);
            end
        ck.push_back(r.range_start);
        cv.push_back(r.fill_value);
        ck.push_back(r.range_stop);
        cv.push_back(end_val);
        foreach (map_keys[i])
            if (map_keys[i] > r.range_stop)
            begin
                ck.push_back(map_keys[i]);
                cv.push_back(map_vals[i]);
            end
        // drop breakpoints that repeat the value in force before them
        prev = map_default;
        foreach (ck[i])
            if (cv[i] != prev)
            begin
                nk.push_back(ck[i]);
                nv.push_back(cv[i]);
                prev = cv[i];
            end
        if (nk.size() > irm_pkg::TABLE_DEPTH)
        begin
            o.status = irm_pkg::ST_FULL;
            return o;
        end
        map_keys = nk;
        map_vals = nv;
        o.status = irm_pkg::ST_DONE;
        return o;
    endfunction

    function automatic int rand_gap();
        if ($urandom_range(0, 3) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                expected_rsps.push_back(apply_request(req_data));
                gap_left <= rand_gap();
                if (pending_reqs.size() > 0 && $urandom_range(0, 1) == 0)
                    req_data <= pending_reqs.pop_front();
                else
                    req_valid <= 1'b0;
            end
            else if (!req_valid)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (pending_reqs.size() > 0)
                begin
                    req_data <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
            end
        end
    end

    // monitor and response stall
    always @(posedge clk)
    begin
        irm_pkg::rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("response with no request outstanding");
                    error_count++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp_data.read_value !== want.read_value)
                    begin
                        $error("read_value expected %0d got %0d",
                               want.read_value, rsp_data.read_value);
                        error_count++;
                    end
                    if (rsp_data.status !== want.status)
                    begin
                        $error("status expected %0d got %0d", want.status, rsp_data.status);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                rsp_stall <= 1'b1;
            end
            else
            begin
                stall_left <= rand_gap();
                rsp_stall <= 1'b0;
            end
        end
    end

    function automatic irm_pkg::req_t make_assign(logic signed [irm_pkg::KEY_BITS-1:0] b,
                                                  logic signed [irm_pkg::KEY_BITS-1:0] e,
                                                  logic [irm_pkg::VALUE_BITS-1:0] v);
        irm_pkg::req_t r;
        r = '0;
        r.action = irm_pkg::ACT_ASSIGN;
        r.range_start = b;
        r.range_stop = e;
        r.fill_value = v;
        r.query_key = $urandom;
        return r;
    endfunction

    function automatic irm_pkg::req_t make_lookup(logic signed [irm_pkg::KEY_BITS-1:0] k);
        irm_pkg::req_t r;
        r = '0;
        r.action = irm_pkg::ACT_LOOKUP;
        r.query_key = k;
        r.range_start = $urandom;
        r.range_stop = $urandom;
        r.fill_value = $urandom;
        return r;
    endfunction

    // keys mostly from a narrow window so intervals overlap, sometimes full range
    function automatic logic signed [irm_pkg::KEY_BITS-1:0] rand_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            return $signed($urandom_range(0, 200)) - 100;
        if (sel == 7)
            return $urandom;
        if (sel == 8)
            return 32'sh7fff_fff0 + $urandom_range(0, 15);
        return 32'sh8000_0000 + $urandom_range(0, 15);
    endfunction

    task automatic drain_and_idle();
        wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_default(logic [irm_pkg::VALUE_BITS-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        map_default = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int count);
        logic signed [irm_pkg::KEY_BITS-1:0] b;
        int w;
        for (int i = 0; i < count; i++)
        begin
            b = rand_key();
            w = $urandom_range(0, 5);
            if (w == 0)
                pending_reqs.push_back(make_assign(b, rand_key(), $urandom));
            else if (w == 1)
                pending_reqs.push_back(make_lookup(rand_key()));
            else if (w == 2)
                pending_reqs.push_back(make_lookup(b));
            else
                pending_reqs.push_back(make_assign(b, b + $urandom_range(1, 20),
                                                   $urandom_range(0, 3) == 0 ?
                                                   map_default : 8'($urandom)));
        end
    endtask

    initial
    begin
        int ds[4];
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, empty interval, merge with default, end key kept
        pending_reqs.push_back(make_lookup(32'sh8000_0000));
        pending_reqs.push_back(make_assign(32'sh8000_0000, 32'sh7fff_ffff, 8'hff));
        pending_reqs.push_back(make_lookup(32'sh7fff_ffff));
        pending_reqs.push_back(make_lookup(32'sh8000_0000));
        pending_reqs.push_back(make_assign(10, 10, 8'h12));
        pending_reqs.push_back(make_assign(20, -5, 8'h12));
        pending_reqs.push_back(make_assign(-10, 10, 8'h00));
        pending_reqs.push_back(make_lookup(9));
        pending_reqs.push_back(make_lookup(10));
        pending_reqs.push_back(make_assign(32'sh8000_0000, 32'sh7fff_ffff, 8'h00));
        pending_reqs.push_back(make_assign(5, 8, 8'h5a));
        pending_reqs.push_back(make_assign(6, 7, 8'ha5));
        pending_reqs.push_back(make_lookup(6));
        pending_reqs.push_back(make_lookup(7));
        pending_reqs.push_back(make_assign(5, 8, 8'h00));
        pending_reqs.push_back(make_lookup(5));
        drain_and_idle();

        // table overflow: many disjoint single-key runs
        for (int i = 0; i < 36; i++)
            pending_reqs.push_back(make_assign(i * 4, i * 4 + 1, 8'(i + 1)));
        pending_reqs.push_back(make_lookup(8));
        drain_and_idle();

        // default changed over a live table
        set_default(8'h03);
        pending_reqs.push_back(make_lookup(-1000));
        pending_reqs.push_back(make_assign(1000, 1001, 8'h03));
        drain_and_idle();
        set_default(8'h00);
        pending_reqs.push_back(make_assign(32'sh8000_0000, 32'sh7fff_ffff, 8'h00));
        drain_and_idle();

        ds = '{8'hff, 8'h00, 8'h5c, 8'h01};
        foreach (ds[i])
        begin
            set_default(ds[i]);
            random_phase(420);
            drain_and_idle();
        end

        if (error_count == 0)
            $display("interval_range_map_core_tb passed");
        else
            $display("interval_range_map_core_tb failed");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("interval_range_map_core_tb failed");
        $finish;
    end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/irm_pkg.sv
hw/rtl/irm_ram.sv
hw/rtl/interval_range_map_core.sv
dv/interval_range_map_core_tb.sv
